// ===== src/sfr_pkg.sv =====
package sfr_pkg;

	localparam int unsigned DATA_LEN = 6;

	// frame positions, counted in bytes taken so far
	localparam logic [3:0] CNT_IDLE   = 4'd0;
	localparam logic [3:0] CNT_TYPE   = 4'd1;
	localparam logic [3:0] CNT_DATA0  = 4'd2;
	localparam logic [3:0] CNT_CRC_LO = 4'd8;
	localparam logic [3:0] CNT_CRC_HI = 4'd9;
	localparam logic [3:0] FRAME_LEN  = 4'd10;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [1:0] ST_VALID    = 2'd0;
	localparam logic [1:0] ST_BAD_TYPE = 2'd1;
	localparam logic [1:0] ST_BAD_CRC  = 2'd2;

	localparam logic [7:0] START_RESET = 8'h5B;
	localparam logic [7:0] TYPE_RESET  = 8'h06;

	localparam logic REG_START_BYTE = 1'b0;
	localparam logic REG_EXP_TYPE   = 1'b1;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] expected_type;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  data_0;
		logic [7:0]  data_1;
		logic [7:0]  data_2;
		logic [7:0]  data_3;
		logic [7:0]  data_4;
		logic [7:0]  data_5;
		logic [15:0] received_crc;
	} result_t;

	// handshake between core and output register
	typedef struct packed {
		logic       push;
		logic [3:0] count;
	} core_stat_t;

	// one byte of CRC-16/Modbus, LSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== src/sfr_ifs.sv =====
interface sfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  data_0;
	logic [7:0]  data_1;
	logic [7:0]  data_2;
	logic [7:0]  data_3;
	logic [7:0]  data_4;
	logic [7:0]  data_5;
	logic [15:0] received_crc;

	modport source (output valid, output status, output data_0, output data_1,
		output data_2, output data_3, output data_4, output data_5,
		output received_crc, input ready);
	modport sink (input valid, input status, input data_0, input data_1,
		input data_2, input data_3, input data_4, input data_5,
		input received_crc, output ready);
endinterface

// ===== src/sfr_cfg_regs.sv =====
module sfr_cfg_regs
	import sfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte    <= START_RESET;
			cfg_q.expected_type <= TYPE_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_START_BYTE: cfg_q.start_byte    <= pwdata[7:0];
				REG_EXP_TYPE:   cfg_q.expected_type <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_START_BYTE: prdata = {24'h000000, cfg_q.start_byte};
			REG_EXP_TYPE:   prdata = {24'h000000, cfg_q.expected_type};
			default:        prdata = 32'h0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== src/sfr_frame_core.sv =====
module sfr_frame_core
	import sfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	output logic       in_ready,
	input  logic       out_room,
	output result_t    result,
	output core_stat_t stat
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic [3:0]  count_q;
	logic [15:0] crc_q;
	logic [7:0]  type_q;
	logic [7:0]  data_q [DATA_LEN];
	logic [7:0]  crc_lo_q;

	logic        is_last;
	logic        go;
	logic [2:0]  data_idx;
	logic [15:0] rcv_crc;

	assign is_last  = (count_q == CNT_CRC_HI);
	// a byte that closes a frame waits until the output register has room
	assign go       = valid_s1 && (!is_last || out_room);
	assign in_ready = !valid_s1 || go;
	assign data_idx = 3'(count_q - CNT_DATA0);
	assign rcv_crc  = {byte_s1, crc_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_IDLE;
			crc_q   <= CRC_INIT;
			type_q  <= 8'h00;
		end else if (go) begin
			if (count_q == CNT_IDLE || count_q >= FRAME_LEN) begin
				count_q <= CNT_IDLE;
				if (byte_s1 == cfg.start_byte) begin
					crc_q   <= crc_feed(CRC_INIT, byte_s1);
					count_q <= CNT_TYPE;
				end
			end else if (count_q == CNT_TYPE) begin
				type_q  <= byte_s1;
				crc_q   <= crc_feed(crc_q, byte_s1);
				count_q <= count_q + 4'd1;
			end else if (count_q < CNT_CRC_LO) begin
				crc_q   <= crc_feed(crc_q, byte_s1);
				count_q <= count_q + 4'd1;
			end else if (count_q == CNT_CRC_LO) begin
				count_q <= count_q + 4'd1;
			end else begin
				count_q <= CNT_IDLE;
				crc_q   <= CRC_INIT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && count_q >= CNT_DATA0 && count_q < CNT_CRC_LO) begin
			data_q[data_idx] <= byte_s1;
		end
		if (go && count_q == CNT_CRC_LO) begin
			crc_lo_q <= byte_s1;
		end
	end

	always_comb begin
		if (type_q != cfg.expected_type) begin
			result.status = ST_BAD_TYPE;
		end else if (crc_q != rcv_crc) begin
			result.status = ST_BAD_CRC;
		end else begin
			result.status = ST_VALID;
		end
		result.data_0       = data_q[0];
		result.data_1       = data_q[1];
		result.data_2       = data_q[2];
		result.data_3       = data_q[3];
		result.data_4       = data_q[4];
		result.data_5       = data_q[5];
		result.received_crc = rcv_crc;
	end

	assign stat.push  = go && is_last;
	assign stat.count = count_q;

endmodule

// ===== src/sfr_out_reg.sv =====
module sfr_out_reg
	import sfr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  result_t      result,
	output logic         room,
	sfr_result_if.source res
);

	logic    valid_q;
	result_t data_q;

	assign room = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (room && push) begin
			data_q <= result;
		end
	end

	assign res.valid        = valid_q;
	assign res.status       = data_q.status;
	assign res.data_0       = data_q.data_0;
	assign res.data_1       = data_q.data_1;
	assign res.data_2       = data_q.data_2;
	assign res.data_3       = data_q.data_3;
	assign res.data_4       = data_q.data_4;
	assign res.data_5       = data_q.data_5;
	assign res.received_crc = data_q.received_crc;

endmodule

// ===== src/sync_frame_receiver_crc16_top.sv =====
// Fixed-length frame receiver with CRC-16/Modbus check. One received byte is
// taken per cycle while the input does not stall; a byte sits in the input
// register while the frame counter and a bytewise CRC update act on it, and a
// finished frame's result is formed from its last byte in the input register and
// loaded into the output register, from which the sink takes it. While idle,
// bytes are dropped until one equals the start_byte register (0x5B); the 10-byte
// frame is start, type, six data bytes, CRC low, CRC high. Status is 0 for a good
// frame, 1 when the type byte differs from expected_type (0x06), 2 on a CRC
// mismatch. A start byte inside a frame is plain data. Input stalls only while a
// frame's last byte waits while the output register holds an untaken result.
module sync_frame_receiver_crc16_top
	import sfr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	sfr_byte_if.sink     rx,
	sfr_result_if.source res
);

	cfg_t       cfg;
	result_t    result;
	core_stat_t stat;
	logic       room;
	logic       in_ready;

	sfr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfr_frame_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (rx.valid),
		.in_byte  (rx.rx_byte),
		.in_ready (in_ready),
		.out_room (room),
		.result   (result),
		.stat     (stat)
	);

	assign rx.ready = in_ready;

	sfr_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (stat.push),
		.result (result),
		.room   (room),
		.res    (res)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count < FRAME_LEN)
		else $error("frame counter out of range");

	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.push |=> stat.count == CNT_IDLE)
		else $error("counter not idle after frame result");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		stat.push |=> res.valid)
		else $error("frame result lost");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.status == ST_VALID || res.status == ST_BAD_TYPE
			|| res.status == ST_BAD_CRC))
		else $error("bad status code");

endmodule
